// ===== hdl/ibmt_pkg.sv =====
// Package for the indicator/buzzer/motor timer block.
// Holds the word types of both channels, command codes, reset values and
// the auto-blink selection function. No dependencies.
package ibmt_pkg;

  // Command codes carried in the op field
  typedef enum logic [3:0] {
    OP_TICK       = 4'd0,
    OP_BUZZER     = 4'd1,
    OP_BLINK      = 4'd2,
    OP_FLASH      = 4'd3,
    OP_SPEED_A    = 4'd4,
    OP_SPEED_B    = 4'd5,
    OP_TIMEOUT    = 4'd6,
    OP_FRONT_SET  = 4'd7,
    OP_FRONT_CLR  = 4'd8,
    OP_FRONT_TGL  = 4'd9,
    OP_RESET_VALS = 4'd10
  } ibmt_op_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_WD_RELOAD  = 2'd0,
    CFG_TURN_THR   = 2'd1,
    CFG_FLASH_ON   = 2'd2
  } ibmt_cfg_idx_t;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [7:0] WD_RELOAD_RST = 8'd10;
  localparam logic [7:0] TURN_THR_RST  = 8'd64;
  localparam logic [7:0] FLASH_ON_RST  = 8'd25;

  localparam logic [4:0] TONE_PERIOD_LONG  = 5'd16;
  localparam logic [4:0] TONE_PERIOD_SHORT = 5'd8;
  localparam logic [7:0] PRESCALE_PRESET   = 8'hFF;
  localparam logic [7:0] BLINK_AUTO_MIN    = 8'd5;
  localparam logic [2:0] BLINK_READ_AUTO   = 3'd5;

  // Blink mode codes
  localparam logic [2:0] BLINK_OFF   = 3'd0;
  localparam logic [2:0] BLINK_RIGHT = 3'd1;
  localparam logic [2:0] BLINK_LEFT  = 3'd2;
  localparam logic [2:0] BLINK_BOTH  = 3'd4;

  typedef struct packed {
    logic [3:0] op;
    logic [7:0] value;
  } ibmt_in_t;

  typedef struct packed {
    logic       left_led;
    logic       right_led;
    logic       front_led;
    logic       top_led;
    logic       buzzer_pin;
    logic [7:0] speed_a;
    logic [7:0] speed_b;
    logic [2:0] blink_readback;
    logic [7:0] buzzer_value;
    logic [7:0] flash_value;
    logic [7:0] timeout_value;
  } ibmt_out_t;

  // Pick the blink pattern from the motor speed difference
  function automatic logic [2:0] auto_blink_mode(input logic [7:0] a,
                                                 input logic [7:0] b,
                                                 input logic [7:0] thr);
    logic [2:0] mode;
    mode = BLINK_BOTH;
    if (a >= b) begin
      if ((a - b) >= thr) mode = BLINK_RIGHT;
    end else begin
      if ((b - a) >= thr) mode = BLINK_LEFT;
    end
    return mode;
  endfunction

endpackage

// ===== hdl/ibmt_in_reg.sv =====
// Input word register of the indicator/buzzer/motor timer.
// Depends on ibmt_pkg for the input word type.
module ibmt_in_reg import ibmt_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  ibmt_in_t in_data,
  input  logic     advance,
  output logic     item_valid,
  output ibmt_in_t item
);

  logic     valid_r;
  logic     valid_nxt;
  ibmt_in_t item_r;

  // Slot frees up when its word moves on this cycle
  assign in_ready  = !valid_r || advance;
  assign valid_nxt = (in_valid && in_ready) ? 1'b1 : (advance ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_data;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

// ===== hdl/ibmt_core.sv =====
// State and update logic of the indicator/buzzer/motor timer: counters,
// modes, PWM values, pin levels and configuration registers.
// Depends on ibmt_pkg for word types, codes and auto_blink_mode().
module ibmt_core import ibmt_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  step_en,
  input  ibmt_in_t              item,
  output ibmt_out_t             result
);

  // configuration
  logic [7:0] wd_reload_r;
  logic [7:0] turn_thr_r;
  logic [7:0] flash_on_r;

  // state
  logic [3:0] td_r, td_nxt;
  logic [7:0] sp_r, sp_nxt;
  logic [4:0] tc_r, tc_nxt;
  logic       short_r, short_nxt;
  logic [7:0] bs_r, bs_nxt;
  logic [2:0] bm_r, bm_nxt;
  logic       auto_r, auto_nxt;
  logic [7:0] fm_r, fm_nxt;
  logic [7:0] we_r, we_nxt;
  logic [7:0] wc_r, wc_nxt;
  logic [7:0] pwm_a_r, pwm_a_nxt;
  logic [7:0] pwm_b_r, pwm_b_nxt;
  logic       left_r, left_nxt;
  logic       right_r, right_nxt;
  logic       front_r, front_nxt;
  logic       top_r, top_nxt;
  logic       buzz_r, buzz_nxt;

  logic       run_poll;
  logic       wrap;
  logic       rearm;
  logic       eval_blink;
  logic [4:0] tc_inc;
  logic [4:0] period;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wd_reload_r <= WD_RELOAD_RST;
      turn_thr_r  <= TURN_THR_RST;
      flash_on_r  <= FLASH_ON_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WD_RELOAD: wd_reload_r <= cfg_wdata;
        CFG_TURN_THR:  turn_thr_r  <= cfg_wdata;
        CFG_FLASH_ON:  flash_on_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    td_nxt     = td_r;
    sp_nxt     = sp_r;
    tc_nxt     = tc_r;
    short_nxt  = short_r;
    bs_nxt     = bs_r;
    bm_nxt     = bm_r;
    auto_nxt   = auto_r;
    fm_nxt     = fm_r;
    we_nxt     = we_r;
    wc_nxt     = wc_r;
    pwm_a_nxt  = pwm_a_r;
    pwm_b_nxt  = pwm_b_r;
    left_nxt   = left_r;
    right_nxt  = right_r;
    front_nxt  = front_r;
    top_nxt    = top_r;
    buzz_nxt   = buzz_r;
    run_poll   = 1'b0;
    wrap       = 1'b0;
    rearm      = 1'b0;
    eval_blink = 1'b0;
    tc_inc     = tc_r + 5'd1;
    period     = short_r ? TONE_PERIOD_SHORT : TONE_PERIOD_LONG;

    case (item.op)
      OP_TICK: begin
        td_nxt   = td_r + 4'd1;
        run_poll = (td_r == 4'hF);
        if (tc_inc >= period) begin
          tc_nxt   = 5'd0;
          buzz_nxt = (bs_r != 8'd0) ? ~buzz_r : 1'b0;
        end else begin
          tc_nxt = tc_inc;
        end
        if (run_poll) begin
          sp_nxt = sp_r + 8'd1;
          wrap   = (sp_r == 8'hFF);
          if (wrap) begin
            short_nxt = ~short_r;
            if (wc_r != 8'd0) begin
              // watchdog expiry stops motors and buzzer
              if (wc_r == 8'd1) begin
                pwm_a_nxt = 8'd0;
                pwm_b_nxt = 8'd0;
                bs_nxt    = 8'd0;
              end
              wc_nxt = wc_r - 8'd1;
            end
          end
          if (bm_r == BLINK_OFF) begin
            left_nxt  = 1'b0;
            right_nxt = 1'b0;
          end else if (bm_r[2]) begin
            left_nxt  = 1'b1;
            right_nxt = 1'b1;
          end else if (wrap) begin
            left_nxt  = bm_r[1] ? ~left_r  : 1'b0;
            right_nxt = bm_r[0] ? ~right_r : 1'b0;
          end
          if (fm_r == 8'd0) begin
            top_nxt = 1'b0;
          end else if (fm_r == 8'd1) begin
            top_nxt = (sp_nxt <= flash_on_r);
          end else begin
            top_nxt = 1'b1;
          end
        end
      end
      OP_BUZZER: begin
        if (item.value != bs_r && item.value != 8'd0) begin
          sp_nxt    = PRESCALE_PRESET;
          short_nxt = 1'b1;
        end
        bs_nxt = item.value;
        rearm  = 1'b1;
      end
      OP_BLINK: begin
        if (item.value >= BLINK_AUTO_MIN) begin
          auto_nxt   = 1'b1;
          eval_blink = 1'b1;
        end else begin
          auto_nxt = 1'b0;
          if (bm_r == BLINK_OFF) sp_nxt = PRESCALE_PRESET;
          left_nxt  = 1'b0;
          right_nxt = 1'b0;
          bm_nxt    = item.value[2:0];
        end
      end
      OP_FLASH: fm_nxt = item.value;
      OP_SPEED_A: begin
        pwm_a_nxt  = item.value;
        rearm      = 1'b1;
        eval_blink = 1'b1;
      end
      OP_SPEED_B: begin
        pwm_b_nxt  = item.value;
        rearm      = 1'b1;
        eval_blink = 1'b1;
      end
      OP_TIMEOUT: begin
        we_nxt = item.value;
        rearm  = 1'b1;
      end
      OP_FRONT_SET: front_nxt = 1'b1;
      OP_FRONT_CLR: front_nxt = 1'b0;
      OP_FRONT_TGL: front_nxt = ~front_r;
      OP_RESET_VALS: begin
        // buzzer off, both speeds zero; no prescaler preset for a zero write
        bs_nxt     = 8'd0;
        pwm_a_nxt  = 8'd0;
        pwm_b_nxt  = 8'd0;
        rearm      = 1'b1;
        eval_blink = 1'b1;
      end
      default: ;
    endcase

    if (rearm && we_nxt != 8'd0) wc_nxt = wd_reload_r;
    if (eval_blink && auto_nxt) bm_nxt = auto_blink_mode(pwm_a_nxt, pwm_b_nxt, turn_thr_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      td_r    <= '0;
      sp_r    <= '0;
      tc_r    <= '0;
      short_r <= 1'b0;
      bs_r    <= '0;
      bm_r    <= BLINK_OFF;
      auto_r  <= 1'b0;
      fm_r    <= '0;
      we_r    <= '0;
      wc_r    <= '0;
      pwm_a_r <= '0;
      pwm_b_r <= '0;
      left_r  <= 1'b0;
      right_r <= 1'b0;
      front_r <= 1'b0;
      top_r   <= 1'b0;
      buzz_r  <= 1'b0;
    end else if (step_en) begin
      td_r    <= td_nxt;
      sp_r    <= sp_nxt;
      tc_r    <= tc_nxt;
      short_r <= short_nxt;
      bs_r    <= bs_nxt;
      bm_r    <= bm_nxt;
      auto_r  <= auto_nxt;
      fm_r    <= fm_nxt;
      we_r    <= we_nxt;
      wc_r    <= wc_nxt;
      pwm_a_r <= pwm_a_nxt;
      pwm_b_r <= pwm_b_nxt;
      left_r  <= left_nxt;
      right_r <= right_nxt;
      front_r <= front_nxt;
      top_r   <= top_nxt;
      buzz_r  <= buzz_nxt;
    end
  end

  // result shows the levels after this word
  always_comb begin
    result.left_led       = left_nxt;
    result.right_led      = right_nxt;
    result.front_led      = front_nxt;
    result.top_led        = top_nxt;
    result.buzzer_pin     = buzz_nxt;
    result.speed_a        = pwm_a_nxt;
    result.speed_b        = pwm_b_nxt;
    result.blink_readback = auto_nxt ? BLINK_READ_AUTO : bm_nxt;
    result.buzzer_value   = bs_nxt;
    result.flash_value    = fm_nxt;
    result.timeout_value  = we_nxt;
  end

  a_tone_range: assert property (@(posedge clk) disable iff (!rst_n)
    tc_r < TONE_PERIOD_LONG)
    else $error("tone counter out of range");

  a_auto_mode: assert property (@(posedge clk) disable iff (!rst_n)
    auto_r |-> (bm_r == BLINK_RIGHT || bm_r == BLINK_LEFT || bm_r == BLINK_BOTH))
    else $error("auto-blink left an illegal blink mode");

  a_poll_adv: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && item.op == OP_TICK && td_r == 4'hF |=> sp_r == $past(sp_r) + 8'd1)
    else $error("prescaler missed a divider wrap");

  a_wd_expire: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && item.op == OP_TICK && td_r == 4'hF && sp_r == 8'hFF && wc_r == 8'd1
    |=> pwm_a_r == 8'd0 && pwm_b_r == 8'd0 && bs_r == 8'd0 && wc_r == 8'd0)
    else $error("watchdog expiry did not stop outputs");

endmodule

// ===== hdl/ibmt_out_reg.sv =====
// Result word register of the indicator/buzzer/motor timer.
// Depends on ibmt_pkg for the result word type.
module ibmt_out_reg import ibmt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      load,
  input  ibmt_out_t load_data,
  output logic      can_load,
  output logic      out_valid,
  input  logic      out_ready,
  output ibmt_out_t out_data
);

  logic      valid_r;
  logic      valid_nxt;
  ibmt_out_t data_r;

  assign can_load  = !valid_r || out_ready;
  assign valid_nxt = load ? 1'b1 : (out_ready ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

// ===== hdl/indicator_buzzer_motor_timer.sv =====
// Top level of the indicator/buzzer/motor timer block.
// Depends on ibmt_pkg, ibmt_in_reg, ibmt_core and ibmt_out_reg.
//
//   port group | dir | handshake          | word
//   -----------+-----+--------------------+--------------------------------
//   in_        | in  | in_valid/in_ready  | ibmt_in_t  (op, value)
//   out_       | out | out_valid/out_ready| ibmt_out_t (pins, values)
//   cfg_       | in  | cfg_we, no wait    | cfg_index selects, cfg_wdata
//
// One word per cycle sustained while out_ready stays high. A word is held
// in the input register, is applied to the state by the core, and its result
// lands in the output register in the same step as the state update.
// Reset (rst_n low, synchronous) clears all state, loads the config reset
// values and empties both registers.
// A stalled out_ready holds the result; the input register still takes one
// more word, after which in_ready drops until the result is taken.
// Config writes take effect at the next edge; write only while idle.
module indicator_buzzer_motor_timer import ibmt_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  ibmt_in_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output ibmt_out_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic      item_valid;
  ibmt_in_t  item;
  logic      can_load;
  logic      step_en;
  ibmt_out_t step_result;

  // a word moves from input register into state and result together
  assign step_en = item_valid && can_load;

  ibmt_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .advance    (step_en),
    .item_valid (item_valid),
    .item       (item)
  );

  ibmt_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .step_en   (step_en),
    .item      (item),
    .result    (step_result)
  );

  ibmt_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step_en),
    .load_data (step_result),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== verif/indicator_buzzer_motor_timer_tb.sv =====
// Self-checking testbench for indicator_buzzer_motor_timer.
// Holds a cycle-free predictor of pins, PWM values and stored settings,
// a queue-fed driver and a checking monitor. Depends on ibmt_pkg and the top.
module indicator_buzzer_motor_timer_tb import ibmt_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  // Op codes the block leaves alone
  localparam logic [3:0] OP_SPARE_LO = 4'd11;
  localparam logic [3:0] OP_SPARE_HI = 4'd15;

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  ibmt_in_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  ibmt_out_t             out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  indicator_buzzer_motor_timer u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop in case the handshake locks up
  initial begin
    #200000;
    $display("CHECKS FAILED");
    $finish;
  end

  // ------------------------------------------------------------------
  // Predictor state: a private copy of the board state and its registers
  // ------------------------------------------------------------------
  logic [7:0] wd_reload_c, turn_thr_c, flash_on_c;

  logic [3:0] div_cnt;      // tick divider, poll on wrap
  logic [7:0] pre_cnt;      // slow prescaler
  logic [4:0] tone_cnt;
  logic       tone_fast;    // 1: 8-tick tone period, 0: 16-tick
  logic [7:0] buzz_set;
  logic [2:0] blink_sel;
  logic       blink_auto;
  logic [7:0] flash_sel;
  logic [7:0] wd_en;
  logic [7:0] wd_cnt;
  logic [7:0] pwm_a_q, pwm_b_q;
  logic       led_l, led_r, led_f, led_t, buzz_pin;

  ibmt_in_t    cmd_q[$];      // words waiting for the driver
  ibmt_out_t   pin_state_q[$]; // predicted results, oldest first
  int unsigned n_pushed  = 0; // words queued that the block acts on
  int unsigned err_count = 0;
  bit          no_gaps   = 1'b0; // set for one phase: neither side idles

  function automatic void clear_board();
    wd_reload_c = WD_RELOAD_RST;
    turn_thr_c  = TURN_THR_RST;
    flash_on_c  = FLASH_ON_RST;
    div_cnt    = '0;
    pre_cnt    = '0;
    tone_cnt   = '0;
    tone_fast  = 1'b0;
    buzz_set   = '0;
    blink_sel  = BLINK_OFF;
    blink_auto = 1'b0;
    flash_sel  = '0;
    wd_en      = '0;
    wd_cnt     = '0;
    pwm_a_q    = '0;
    pwm_b_q    = '0;
    {led_l, led_r, led_f, led_t, buzz_pin} = '0;
  endfunction

  // Any write that touches the motors or buzzer keeps the watchdog fed
  function automatic void feed_watchdog();
    if (wd_en != 0) wd_cnt = wd_reload_c;
  endfunction

  // Auto-blink: signal a turn toward the slower side once the speed gap
  // reaches the threshold, otherwise both blinkers on
  function automatic void steer_blinkers();
    if (!blink_auto) return;
    if (pwm_a_q >= pwm_b_q)
      blink_sel = (pwm_a_q - pwm_b_q >= turn_thr_c) ? BLINK_RIGHT : BLINK_BOTH;
    else
      blink_sel = (pwm_b_q - pwm_a_q >= turn_thr_c) ? BLINK_LEFT : BLINK_BOTH;
  endfunction

  function automatic void set_buzzer(logic [7:0] v);
    // Only an actual change to a nonzero tone restarts the slow count
    if (buzz_set != v) begin
      if (v != 0) begin
        pre_cnt   = PRESCALE_PRESET;
        tone_fast = 1'b1;
      end
      buzz_set = v;
    end
    feed_watchdog();
  endfunction

  function automatic void set_speed(bit motor_b, logic [7:0] v);
    if (motor_b) pwm_b_q = v;
    else pwm_a_q = v;
    feed_watchdog();
    steer_blinkers();
  endfunction

  function automatic void set_blink(logic [7:0] v);
    if (v >= BLINK_AUTO_MIN) begin
      // auto mode keeps the current pin levels
      blink_auto = 1'b1;
      steer_blinkers();
    end else begin
      blink_auto = 1'b0;
      if (blink_sel == BLINK_OFF) pre_cnt = PRESCALE_PRESET;
      led_l     = 1'b0;
      led_r     = 1'b0;
      blink_sel = v[2:0];
    end
  endfunction

  // Slow poll, once every sixteen ticks
  function automatic void slow_poll();
    pre_cnt = pre_cnt + 8'd1;
    if (pre_cnt == 0) begin
      tone_fast = ~tone_fast;
      if (wd_cnt != 0) begin
        // watchdog runs out: motors and buzzer off
        if (wd_cnt == 1) begin
          pwm_a_q  = '0;
          pwm_b_q  = '0;
          buzz_set = '0;
        end
        wd_cnt = wd_cnt - 8'd1;
      end
    end
    if (blink_sel == BLINK_OFF) begin
      led_l = 1'b0;
      led_r = 1'b0;
    end else if (blink_sel[2]) begin
      led_l = 1'b1;
      led_r = 1'b1;
    end else if (pre_cnt == 0) begin
      led_l = blink_sel[1] ? ~led_l : 1'b0;
      led_r = blink_sel[0] ? ~led_r : 1'b0;
    end
    if (flash_sel == 0) led_t = 1'b0;
    else if (flash_sel == 1) led_t = (pre_cnt <= flash_on_c);
    else led_t = 1'b1;
  endfunction

  function automatic void timer_tick();
    logic [4:0] period;
    logic       run_poll;
    period   = tone_fast ? TONE_PERIOD_SHORT : TONE_PERIOD_LONG;
    div_cnt  = div_cnt + 4'd1;
    run_poll = (div_cnt == 0);
    tone_cnt = tone_cnt + 5'd1;
    if (tone_cnt >= period) begin
      tone_cnt = '0;
      buzz_pin = (buzz_set != 0) ? ~buzz_pin : 1'b0;
    end
    if (run_poll) slow_poll();
  endfunction

  // Apply one command word, return the levels it leaves behind
  function automatic ibmt_out_t apply_command(ibmt_in_t w);
    ibmt_out_t r;
    case (ibmt_op_t'(w.op))
      OP_TICK:       timer_tick();
      OP_BUZZER:     set_buzzer(w.value);
      OP_BLINK:      set_blink(w.value);
      OP_FLASH:      flash_sel = w.value;
      OP_SPEED_A:    set_speed(1'b0, w.value);
      OP_SPEED_B:    set_speed(1'b1, w.value);
      OP_TIMEOUT: begin
        wd_en = w.value;
        feed_watchdog();
      end
      OP_FRONT_SET:  led_f = 1'b1;
      OP_FRONT_CLR:  led_f = 1'b0;
      OP_FRONT_TGL:  led_f = ~led_f;
      OP_RESET_VALS: begin
        set_buzzer('0);
        set_speed(1'b0, '0);
        set_speed(1'b1, '0);
      end
      default: ;  // spare codes: no effect
    endcase
    r.left_led       = led_l;
    r.right_led      = led_r;
    r.front_led      = led_f;
    r.top_led        = led_t;
    r.buzzer_pin     = buzz_pin;
    r.speed_a        = pwm_a_q;
    r.speed_b        = pwm_b_q;
    r.blink_readback = blink_auto ? BLINK_READ_AUTO : blink_sel;
    r.buzzer_value   = buzz_set;
    r.flash_value    = flash_sel;
    r.timeout_value  = wd_en;
    return r;
  endfunction

  // ------------------------------------------------------------------
  // Stimulus helpers
  // ------------------------------------------------------------------
  function automatic void push_word(logic [3:0] op, logic [7:0] v);
    ibmt_in_t w;
    w.op    = op;
    w.value = v;
    cmd_q.push_back(w);
    if (op <= OP_RESET_VALS) n_pushed++;
  endfunction

  function automatic void push_ticks(int unsigned n);
    repeat (n) push_word(OP_TICK, 8'($urandom));
  endfunction

  // Bytes leaning toward the edges of the range
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 5))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h01;
      default: return 8'($urandom);
    endcase
  endfunction

  // Random part: mostly short scenarios (set something up, then let the
  // timer run through a poll or two), plus some loose words
  task automatic queue_random_words(int unsigned target);
    int unsigned start;
    logic [7:0]  a, b;
    start = n_pushed;
    while (n_pushed - start < target) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: push_ticks($urandom_range(1, 40));
        4: begin
          // arm the watchdog, run the motors and buzzer, then coast
          push_word(OP_TIMEOUT, ($urandom_range(0, 4) == 0) ? 8'h00 : pick_byte());
          push_word(OP_SPEED_A, pick_byte());
          push_word(OP_SPEED_B, pick_byte());
          push_word(OP_BUZZER, pick_byte());
          push_ticks($urandom_range(17, 48));
        end
        5: begin
          push_word(OP_BLINK, ($urandom_range(0, 3) == 0) ? pick_byte()
                                                          : 8'($urandom_range(0, 7)));
          push_ticks($urandom_range(16, 48));
        end
        6: begin
          case ($urandom_range(0, 3))
            0:       push_word(OP_FLASH, 8'h00);
            3:       push_word(OP_FLASH, pick_byte());
            default: push_word(OP_FLASH, 8'h01);
          endcase
          push_ticks($urandom_range(16, 40));
        end
        7: begin
          // auto-blink with a speed gap right around the threshold
          a = 8'($urandom);
          b = a + turn_thr_c + 8'($urandom_range(0, 2)) - 8'd1;
          push_word(OP_BLINK, 8'($urandom_range(BLINK_AUTO_MIN, 255)));
          if ($urandom_range(0, 1)) begin
            push_word(OP_SPEED_A, a);
            push_word(OP_SPEED_B, b);
          end else begin
            push_word(OP_SPEED_B, a);
            push_word(OP_SPEED_A, b);
          end
          push_ticks($urandom_range(1, 32));
        end
        8: push_word(4'($urandom_range(OP_FRONT_SET, OP_SPARE_HI)), 8'($urandom));
        default: push_word(4'($urandom_range(OP_TICK, OP_SPARE_HI)), 8'($urandom));
      endcase
    end
  endtask

  // Wait until the driver is empty and every prediction has been matched
  task automatic wait_drained();
    do @(negedge clk);
    while (cmd_q.size() != 0 || in_valid || pin_state_q.size() != 0);
    // leave a little margin after the last result
    repeat (4) @(negedge clk);
  endtask

  // Register write; only called while the block is idle
  task automatic write_reg(ibmt_cfg_idx_t idx, logic [7:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      CFG_WD_RELOAD: wd_reload_c = v;
      CFG_TURN_THR:  turn_thr_c  = v;
      CFG_FLASH_ON:  flash_on_c  = v;
      default: ;
    endcase
  endtask

  // ------------------------------------------------------------------
  // Checking
  // ------------------------------------------------------------------
  task automatic report_mismatch(string msg);
    err_count++;
    if (err_count <= 200) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  // Driver: in_valid holds with a steady word until it is taken. The word
  // accepted at this edge is run through the predictor right here.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) pin_state_q.push_back(apply_command(in_data));
      if (!in_valid || in_ready) begin
        if (cmd_q.size() != 0 && (no_gaps || $urandom_range(0, 99) >= 11)) begin
          in_valid <= 1'b1;
          in_data  <= cmd_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random back-pressure, each taken result against the oldest
  // prediction
  always @(posedge clk) begin
    ibmt_out_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pin_state_q.size() == 0) begin
          report_mismatch("result word with no prediction pending");
        end else begin
          want = pin_state_q.pop_front();
          check_field("left_led",       8'(out_data.left_led),   8'(want.left_led));
          check_field("right_led",      8'(out_data.right_led),  8'(want.right_led));
          check_field("front_led",      8'(out_data.front_led),  8'(want.front_led));
          check_field("top_led",        8'(out_data.top_led),    8'(want.top_led));
          check_field("buzzer_pin",     8'(out_data.buzzer_pin), 8'(want.buzzer_pin));
          check_field("speed_a",        out_data.speed_a,        want.speed_a);
          check_field("speed_b",        out_data.speed_b,        want.speed_b);
          check_field("blink_readback", 8'(out_data.blink_readback),
                      8'(want.blink_readback));
          check_field("buzzer_value",   out_data.buzzer_value,   want.buzzer_value);
          check_field("flash_value",    out_data.flash_value,    want.flash_value);
          check_field("timeout_value",  out_data.timeout_value,  want.timeout_value);
        end
      end
      out_ready <= no_gaps || ($urandom_range(0, 99) >= 11);
    end
  end

  // ------------------------------------------------------------------
  // Test sequence
  // ------------------------------------------------------------------
  initial begin
    clear_board();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: front LED ops, spare codes, speed extremes, auto-blink on
    // both sides of the threshold, blink write from mode zero, buzzer and
    // watchdog setup, value reset
    push_word(OP_FRONT_SET, 8'h00);
    push_word(OP_FRONT_TGL, 8'hFF);
    push_word(OP_FRONT_CLR, 8'h00);
    push_word(OP_FRONT_TGL, 8'h00);
    push_word(OP_SPARE_LO, 8'hAA);
    push_word(OP_SPARE_HI, 8'h55);
    push_word(OP_SPEED_A, 8'hFF);
    push_word(OP_SPEED_B, 8'h00);
    push_word(OP_BLINK, 8'd7);        // auto: big gap, right
    push_word(OP_SPEED_B, 8'hFF);     // equal speeds, both
    push_word(OP_BLINK, 8'hFF);
    push_word(OP_BLINK, BLINK_OFF);
    push_word(OP_BLINK, BLINK_LEFT);  // from mode zero: prescaler preset
    push_word(OP_FLASH, 8'h01);
    push_word(OP_TIMEOUT, 8'hFF);
    push_word(OP_BUZZER, 8'hFF);
    push_word(OP_RESET_VALS, 8'hFF);
    push_word(OP_BUZZER, 8'h01);
    push_word(OP_BLINK, BLINK_AUTO_MIN);
    push_word(OP_SPEED_A, TURN_THR_RST);          // gap equals threshold
    push_word(OP_SPEED_B, TURN_THR_RST << 1);     // gap equals threshold, other way
    push_ticks(4);

    queue_random_words(250);
    wait_drained();

    // Shortest watchdog, zero threshold and flash window
    write_reg(CFG_WD_RELOAD, 8'd1);
    write_reg(CFG_TURN_THR, 8'd0);
    write_reg(CFG_FLASH_ON, 8'd0);
    queue_random_words(250);
    wait_drained();

    // Top of every register
    write_reg(CFG_WD_RELOAD, 8'hFF);
    write_reg(CFG_TURN_THR, 8'hFF);
    write_reg(CFG_FLASH_ON, 8'hFF);
    queue_random_words(250);
    wait_drained();

    // Reload of zero disables expiry; this phase runs without any gaps
    write_reg(CFG_WD_RELOAD, 8'd0);
    write_reg(CFG_TURN_THR, 8'($urandom));
    write_reg(CFG_FLASH_ON, 8'($urandom));
    no_gaps = 1'b1;
    queue_random_words(300);
    wait_drained();
    no_gaps = 1'b0;

    write_reg(CFG_WD_RELOAD, 8'd2);
    write_reg(CFG_TURN_THR, 8'd128);
    write_reg(CFG_FLASH_ON, 8'd3);
    queue_random_words(250);
    wait_drained();

    repeat (10) @(negedge clk);
    if (err_count == 0 && pin_state_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/ibmt_pkg.sv
hdl/ibmt_in_reg.sv
hdl/ibmt_core.sv
hdl/ibmt_out_reg.sv
hdl/indicator_buzzer_motor_timer.sv
verif/indicator_buzzer_motor_timer_tb.sv
